// ----- rtl/i2cbm_pkg.sv -----
package i2cbm_pkg;

   // sample index width; the index wraps at this many bits
   localparam int IdxW = 32;
   localparam int ValW = 10;
   localparam int ErrCntW = 17;
   localparam int LimitW = 16;
   localparam int BitCntW = 4;

   localparam logic [BitCntW-1:0] BitsPerByte = BitCntW'(8);
   localparam logic [7:0] TenBitMask = 8'hF8;
   localparam logic [7:0] TenBitTag = 8'hF0;
   localparam logic [7:0] TenBitHiMask = 8'h06;
   localparam logic [7:0] DirMask = 8'h01;
   localparam logic [7:0] ByteMask = 8'hFF;
   localparam logic [LimitW-1:0] LimitReset = LimitW'(100);

   // result queue between decoder and output stage
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);

   localparam int ReqDataW = 8;
   localparam int RspBitsW = ValW + 2 * IdxW + 1;
   localparam int RspDataW = ((RspBitsW + 7) / 8) * 8;
   localparam int RspPadW = RspDataW - RspBitsW;

   // register map: register index taken from paddr[2]
   localparam int CsrAddrW = 3;
   localparam logic CsrErrLimit = 1'b0;

   typedef enum logic [3:0] {
      KIND_START = 4'd0,
      KIND_STOP  = 4'd1,
      KIND_ACK   = 4'd2,
      KIND_NACK  = 4'd3,
      KIND_DATA  = 4'd4,
      KIND_A7W   = 4'd5,
      KIND_A7R   = 4'd6,
      KIND_A10W  = 4'd7,
      KIND_A10R  = 4'd8,
      KIND_ERROR = 4'd9
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [ValW-1:0]      value;
      logic [IdxW-1:0]      first_sample;
      logic [IdxW-1:0]      last_sample;
      logic                 has_end;
   } event_type;

endpackage

// ----- rtl/i2cbm_decode.sv -----
module i2cbm_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic                           scl,
   input  logic                           sda,
   input  logic [i2cbm_pkg::LimitW-1:0]   error_limit,
   output logic                           evt_push,
   output i2cbm_pkg::event_type           evt
);

   logic                            prev_clk_ff, prev_clk_in;
   logic                            prev_dat_ff, prev_dat_in;
   logic                            primed_ff, primed_in;
   logic                            start_seen_ff, start_seen_in;
   logic                            expect_addr_ff, expect_addr_in;
   logic                            ten_pend_ff, ten_pend_in;
   logic                            ten_read_ff, ten_read_in;
   logic [i2cbm_pkg::ValW-1:0]      addr_hold_ff, addr_hold_in;
   logic [i2cbm_pkg::BitCntW-1:0]   bits_left_ff, bits_left_in;
   logic [7:0]                      shift_ff, shift_in;
   logic [i2cbm_pkg::IdxW-1:0]      byte_start_ff, byte_start_in;
   logic [i2cbm_pkg::IdxW-1:0]      last_fall_ff, last_fall_in;
   logic [i2cbm_pkg::IdxW-1:0]      idx_ff, idx_in;
   logic [i2cbm_pkg::ErrCntW-1:0]   err_cnt_ff, err_cnt_in;
   logic                            halted_ff, halted_in;
   logic                            emit;
   logic                            rise_err;
   logic [7:0]                      b;
   i2cbm_pkg::event_type            evt_in;

   assign b = shift_ff & i2cbm_pkg::ByteMask;

   always_comb begin
      prev_clk_in    = prev_clk_ff;
      prev_dat_in    = prev_dat_ff;
      primed_in      = primed_ff;
      start_seen_in  = start_seen_ff;
      expect_addr_in = expect_addr_ff;
      ten_pend_in    = ten_pend_ff;
      ten_read_in    = ten_read_ff;
      addr_hold_in   = addr_hold_ff;
      bits_left_in   = bits_left_ff;
      shift_in       = shift_ff;
      byte_start_in  = byte_start_ff;
      last_fall_in   = last_fall_ff;
      idx_in         = idx_ff;
      err_cnt_in     = err_cnt_ff;
      halted_in      = halted_ff;
      emit           = 1'b0;
      rise_err       = 1'b0;
      evt_in         = '0;

      if (!halted_ff) begin
         if (!primed_ff) begin
            primed_in   = 1'b1;
            prev_clk_in = scl;
            prev_dat_in = sda;
            idx_in      = idx_ff + 1'b1;
         end else begin
            if (prev_clk_ff && !scl) begin
               // falling edge: open or close a byte
               if (start_seen_ff) begin
                  last_fall_in = idx_ff;
                  if (bits_left_ff == i2cbm_pkg::BitsPerByte) begin
                     byte_start_in = idx_ff;
                  end else if (bits_left_ff == '0) begin
                     if (expect_addr_ff) begin
                        if ((b & i2cbm_pkg::TenBitMask) == i2cbm_pkg::TenBitTag) begin
                           // first byte of a 10-bit address: hold high bits, no word
                           ten_pend_in  = 1'b1;
                           addr_hold_in = {b[2:1] & i2cbm_pkg::TenBitHiMask[2:1], 8'd0};
                           ten_read_in  = |(b & i2cbm_pkg::DirMask);
                        end else begin
                           emit = 1'b1;
                           evt_in.first_sample = byte_start_ff;
                           evt_in.last_sample  = idx_ff;
                           evt_in.has_end      = 1'b1;
                           if (ten_pend_ff) begin
                              addr_hold_in = addr_hold_ff | {2'b00, b};
                              evt_in.kind  = ten_read_ff ? i2cbm_pkg::KIND_A10R
                                                         : i2cbm_pkg::KIND_A10W;
                           end else begin
                              addr_hold_in = {3'b000, b[7:1]};
                              evt_in.kind  = b[0] ? i2cbm_pkg::KIND_A7R
                                                  : i2cbm_pkg::KIND_A7W;
                           end
                           evt_in.value   = addr_hold_in;
                           ten_pend_in    = 1'b0;
                           expect_addr_in = 1'b0;
                        end
                     end else begin
                        emit = 1'b1;
                        evt_in.kind         = i2cbm_pkg::KIND_DATA;
                        evt_in.value        = {2'b00, b};
                        evt_in.first_sample = byte_start_ff;
                        evt_in.last_sample  = idx_ff;
                        evt_in.has_end      = 1'b1;
                     end
                  end
               end
            end else if (!prev_clk_ff && scl) begin
               // rising edge: take a bit or the acknowledge
               if (start_seen_ff) begin
                  if (prev_dat_ff != sda) begin
                     rise_err = 1'b1;
                     emit = 1'b1;
                     evt_in.kind         = i2cbm_pkg::KIND_ERROR;
                     evt_in.first_sample = idx_ff;
                     if (err_cnt_in != '1) err_cnt_in = err_cnt_in + 1'b1;
                  end else if (bits_left_ff != '0) begin
                     bits_left_in = bits_left_ff - 1'b1;
                     if (sda) shift_in[bits_left_in[2:0]] = 1'b1;
                  end else begin
                     emit = 1'b1;
                     evt_in.kind = sda ? i2cbm_pkg::KIND_NACK : i2cbm_pkg::KIND_ACK;
                     evt_in.first_sample = last_fall_ff;
                     bits_left_in = i2cbm_pkg::BitsPerByte;
                     shift_in     = '0;
                  end
               end
            end

            // data moved while clock high: start, stop or bus error
            if (!rise_err && scl && (sda != prev_dat_ff)) begin
               if (bits_left_in != '0 && bits_left_in < i2cbm_pkg::BitCntW'(7)) begin
                  bits_left_in = i2cbm_pkg::BitsPerByte;
                  shift_in     = '0;
                  emit         = 1'b1;
                  evt_in       = '0;
                  evt_in.kind  = i2cbm_pkg::KIND_ERROR;
                  evt_in.first_sample = idx_ff;
                  if (err_cnt_in != '1) err_cnt_in = err_cnt_in + 1'b1;
               end else begin
                  if (prev_dat_ff && !sda) begin
                     emit           = 1'b1;
                     evt_in         = '0;
                     evt_in.kind    = i2cbm_pkg::KIND_START;
                     evt_in.first_sample = idx_ff;
                     expect_addr_in = 1'b1;
                     start_seen_in  = 1'b1;
                  end else if (start_seen_ff) begin
                     emit        = 1'b1;
                     evt_in      = '0;
                     evt_in.kind = i2cbm_pkg::KIND_STOP;
                     evt_in.first_sample = idx_ff;
                  end
                  shift_in     = '0;
                  bits_left_in = i2cbm_pkg::BitsPerByte;
               end
            end

            prev_dat_in = sda;
            prev_clk_in = scl;
            idx_in      = idx_ff + 1'b1;
            halted_in   = err_cnt_in > {1'b0, error_limit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_clk_ff    <= 1'b0;
         prev_dat_ff    <= 1'b0;
         primed_ff      <= 1'b0;
         start_seen_ff  <= 1'b0;
         expect_addr_ff <= 1'b0;
         ten_pend_ff    <= 1'b0;
         ten_read_ff    <= 1'b0;
         addr_hold_ff   <= '0;
         bits_left_ff   <= i2cbm_pkg::BitsPerByte;
         shift_ff       <= '0;
         byte_start_ff  <= '0;
         last_fall_ff   <= '0;
         idx_ff         <= '0;
         err_cnt_ff     <= '0;
         halted_ff      <= 1'b0;
      end else if (step) begin
         prev_clk_ff    <= prev_clk_in;
         prev_dat_ff    <= prev_dat_in;
         primed_ff      <= primed_in;
         start_seen_ff  <= start_seen_in;
         expect_addr_ff <= expect_addr_in;
         ten_pend_ff    <= ten_pend_in;
         ten_read_ff    <= ten_read_in;
         addr_hold_ff   <= addr_hold_in;
         bits_left_ff   <= bits_left_in;
         shift_ff       <= shift_in;
         byte_start_ff  <= byte_start_in;
         last_fall_ff   <= last_fall_in;
         idx_ff         <= idx_in;
         err_cnt_ff     <= err_cnt_in;
         halted_ff      <= halted_in;
      end
   end

   assign evt_push = step && emit;
   assign evt      = evt_in;

`ifndef SYNTHESIS
   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("decoder left halted state without reset");

   a_no_word_halted: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !evt_push)
      else $error("word produced while halted");

   a_bits_range: assert property (@(posedge clock) disable iff (reset)
      bits_left_ff <= i2cbm_pkg::BitsPerByte)
      else $error("bit count out of range");
`endif

endmodule

// ----- rtl/i2cbm_queue.sv -----
module i2cbm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  i2cbm_pkg::event_type  push_evt,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output i2cbm_pkg::event_type  head_evt
);

   i2cbm_pkg::event_type              mem [i2cbm_pkg::QDepth];
   logic [i2cbm_pkg::QPtrW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [i2cbm_pkg::QPtrW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [i2cbm_pkg::QCntW-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + i2cbm_pkg::QCntW'(push) - i2cbm_pkg::QCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_evt;
   end

   assign full       = (count_ff == i2cbm_pkg::QCntW'(i2cbm_pkg::QDepth));
   assign head_valid = (count_ff != '0);
   assign head_evt   = mem[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

// ----- rtl/i2cbm_out.sv -----
module i2cbm_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  i2cbm_pkg::event_type  head_evt,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output i2cbm_pkg::event_type  out_evt
);

   logic                  valid_ff, valid_in;
   i2cbm_pkg::event_type  evt_ff;

   // refill whenever the held word leaves or the register is empty
   assign pop      = head_valid && (!valid_ff || out_ready);
   assign valid_in = pop || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) evt_ff <= head_evt;
   end

   assign out_valid = valid_ff;
   assign out_evt   = evt_ff;

`ifndef SYNTHESIS
   a_has_end_kind: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (evt_ff.has_end == (evt_ff.kind == i2cbm_pkg::KIND_DATA
         || evt_ff.kind == i2cbm_pkg::KIND_A7W || evt_ff.kind == i2cbm_pkg::KIND_A7R
         || evt_ff.kind == i2cbm_pkg::KIND_A10W || evt_ff.kind == i2cbm_pkg::KIND_A10R)))
      else $error("has_end does not match word kind");
`endif

endmodule

// ----- rtl/i2c_bus_monitor_core.sv -----
// channel | dir | handshake            | contents
// req     | in  | req_tvalid/tready    | one scl/sda sample per word
// rsp     | out | rsp_tvalid/tready    | decoded bus event, kind in tuser
// csr     | in  | psel/penable/pready  | error_limit at byte address 0
//
// One sample is accepted every clock while the queue is not full; its event reaches
// rsp through a four-word queue and an output register.
// req_tready falls only when the queue is full, i.e. after rsp stalls long
// enough to back up five events (four queued, one in the output register).
// Reset is synchronous; the decoder restarts unprimed and error_limit returns to 100.
module i2c_bus_monitor_core (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [i2cbm_pkg::ReqDataW-1:0]    req_tdata,  // scl, sda

   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [i2cbm_pkg::RspDataW-1:0]    rsp_tdata,  // value, first_sample,
                                                         // last_sample, has_end
   output logic [3:0]                        rsp_tuser,  // kind

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [i2cbm_pkg::CsrAddrW-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic [i2cbm_pkg::LimitW-1:0]   limit_ff;
   logic                           step;
   logic                           q_full;
   logic                           evt_push;
   i2cbm_pkg::event_type           evt;
   logic                           head_valid;
   i2cbm_pkg::event_type           head_evt;
   logic                           pop;
   i2cbm_pkg::event_type           out_evt;
   logic                           csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == i2cbm_pkg::CsrErrLimit);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= i2cbm_pkg::LimitReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         limit_ff <= csr_pwdata[i2cbm_pkg::LimitW-1:0];
      end
   end

   assign csr_prdata = csr_hit ? {{(32 - i2cbm_pkg::LimitW){1'b0}}, limit_ff} : '0;

   assign req_tready = !q_full;
   assign step       = req_tvalid && req_tready;

   i2cbm_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .scl         (req_tdata[0]),
      .sda         (req_tdata[1]),
      .error_limit (limit_ff),
      .evt_push    (evt_push),
      .evt         (evt)
   );

   i2cbm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (evt_push),
      .push_evt   (evt),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_evt   (head_evt)
   );

   i2cbm_out u_out (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_evt   (head_evt),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_evt    (out_evt)
   );

   assign rsp_tuser = out_evt.kind;
   assign rsp_tdata = {{i2cbm_pkg::RspPadW{1'b0}}, out_evt.has_end, out_evt.last_sample,
                       out_evt.first_sample, out_evt.value};

endmodule
